FILE: src/ghbp_pkg.sv
// Shared constants and defaults for the global history branch predictor.
`default_nettype none

package ghbp_pkg;

  localparam int HISTORY_BITS_DEFAULT = 5;
  localparam int COUNT_BITS_DEFAULT   = 16;
  localparam int CTR_BITS             = 2;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  localparam logic [CTR_BITS-1:0] CTR_INIT = 2'd3;
  localparam logic [CTR_BITS-1:0] CTR_MAX  = 2'd3;
  localparam logic [CTR_BITS-1:0] CTR_MIN  = 2'd0;

endpackage

`default_nettype wire

FILE: src/ghbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ghbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/ghbp_update.sv
// Next-value logic for one table entry: counter step, outcome counts and prediction.
`default_nettype none

module ghbp_update #(
  parameter int COUNT_BITS = ghbp_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                          cmd,
  input  wire logic                          taken,
  input  wire logic [ghbp_pkg::CTR_BITS-1:0] counter_old,
  input  wire logic [COUNT_BITS-1:0]         taken_old,
  input  wire logic [COUNT_BITS-1:0]         not_taken_old,
  output logic      [ghbp_pkg::CTR_BITS-1:0] counter_new,
  output logic      [COUNT_BITS-1:0]         taken_new,
  output logic      [COUNT_BITS-1:0]         not_taken_new,
  output logic                               predicted_taken,
  output logic                               mispredicted
);

  logic is_update;

  assign is_update       = (cmd == ghbp_pkg::CMD_UPDATE);
  assign predicted_taken = counter_old[ghbp_pkg::CTR_BITS-1];
  assign mispredicted    = is_update && (predicted_taken != taken);

  always_comb begin
    counter_new   = counter_old;
    taken_new     = taken_old;
    not_taken_new = not_taken_old;
    if (is_update) begin
      if (taken) begin
        if (counter_old != ghbp_pkg::CTR_MAX) begin
          counter_new = counter_old + 1'b1;
        end
        if (taken_old != {COUNT_BITS{1'b1}}) begin
          taken_new = taken_old + 1'b1;
        end
      end else begin
        if (counter_old != ghbp_pkg::CTR_MIN) begin
          counter_new = counter_old - 1'b1;
        end
        if (not_taken_old != {COUNT_BITS{1'b1}}) begin
          not_taken_new = not_taken_old + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/global_history_branch_predictor_core.sv
// Top level of the global history branch predictor.
`default_nettype none

// Takes one word per cycle while item_stall is low and returns one result word per
// input word. A word has its table entry read at the clock edge that accepts it;
// the entry is then updated and registered as a result when the result register
// can advance. The table lives in a RAM with registered read. A write-back bypass
// register covers back-to-back words that hit the same entry. While a result word
// is stalled the block holds one further word, after which item_stall rises. After
// reset the table is swept to its initial state, and item_stall is high throughout
// the sweep.
module global_history_branch_predictor_core #(
  parameter int HISTORY_BITS = ghbp_pkg::HISTORY_BITS_DEFAULT,
  parameter int COUNT_BITS   = ghbp_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_valid,
  output logic                         item_stall,
  input  wire logic                    cmd,
  input  wire logic                    taken,
  input  wire logic [HISTORY_BITS-1:0] read_index,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output logic                         predicted_taken,
  output logic                         mispredicted,
  output logic      [HISTORY_BITS-1:0] entry_index,
  output logic [ghbp_pkg::CTR_BITS-1:0] counter_value,
  output logic      [COUNT_BITS-1:0]   taken_total,
  output logic      [COUNT_BITS-1:0]   not_taken_total
);

  localparam int DEPTH   = 1 << HISTORY_BITS;
  localparam int ENTRY_W = ghbp_pkg::CTR_BITS + 2 * COUNT_BITS;

  logic                    clearing;
  logic [HISTORY_BITS-1:0] clear_addr;
  logic [HISTORY_BITS-1:0] history;
  logic [HISTORY_BITS-1:0] history_next;

  logic                    s1_valid;
  logic                    s1_cmd;
  logic                    s1_taken;
  logic [HISTORY_BITS-1:0] s1_index;

  logic                    fwd_valid;
  logic [HISTORY_BITS-1:0] fwd_addr;
  logic [ENTRY_W-1:0]      fwd_data;

  logic                    advance;
  logic                    accept;
  logic [HISTORY_BITS-1:0] rd_addr;
  logic [ENTRY_W-1:0]      rd_data;
  logic [ENTRY_W-1:0]      old_entry;
  logic [ENTRY_W-1:0]      new_entry;
  logic                    s1_write;
  logic                    ram_we;
  logic [HISTORY_BITS-1:0] ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;

  logic [ghbp_pkg::CTR_BITS-1:0] ctr_new;
  logic [COUNT_BITS-1:0]         tk_new;
  logic [COUNT_BITS-1:0]         ntk_new;
  logic                          pred;
  logic                          miss;

  assign advance    = !(result_valid && result_stall);
  assign item_stall = clearing || (s1_valid && !advance);
  assign accept     = item_valid && !item_stall;
  assign rd_addr    = (cmd == ghbp_pkg::CMD_READ) ? read_index : history;

  assign history_next = HISTORY_BITS'({taken, history} >> 1);

  assign old_entry = (fwd_valid && (fwd_addr == s1_index)) ? fwd_data : rd_data;
  assign new_entry = {ctr_new, tk_new, ntk_new};
  assign s1_write  = s1_valid && advance && (s1_cmd == ghbp_pkg::CMD_UPDATE);

  assign ram_we    = clearing || s1_write;
  assign ram_waddr = clearing ? clear_addr : s1_index;
  assign ram_wdata = clearing ? {ghbp_pkg::CTR_INIT, {(2 * COUNT_BITS){1'b0}}} : new_entry;

  ghbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ghbp_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .cmd             (s1_cmd),
    .taken           (s1_taken),
    .counter_old     (old_entry[ENTRY_W-1 -: ghbp_pkg::CTR_BITS]),
    .taken_old       (old_entry[2*COUNT_BITS-1 -: COUNT_BITS]),
    .not_taken_old   (old_entry[COUNT_BITS-1:0]),
    .counter_new     (ctr_new),
    .taken_new       (tk_new),
    .not_taken_new   (ntk_new),
    .predicted_taken (pred),
    .mispredicted    (miss)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clear_addr   <= '0;
      history      <= '0;
      s1_valid     <= 1'b0;
      fwd_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clear_addr <= clear_addr + 1'b1;
        if (clear_addr == {HISTORY_BITS{1'b1}}) begin
          clearing <= 1'b0;
        end
      end

      if (accept) begin
        s1_valid <= 1'b1;
        if (cmd == ghbp_pkg::CMD_UPDATE) begin
          history <= history_next;
        end
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (s1_write) begin
        fwd_valid <= 1'b1;
      end

      if (advance) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= cmd;
      s1_taken <= taken;
      s1_index <= rd_addr;
    end
    if (s1_write) begin
      fwd_addr <= s1_index;
      fwd_data <= new_entry;
    end
    if (s1_valid && advance) begin
      predicted_taken <= pred;
      mispredicted    <= miss;
      entry_index     <= s1_index;
      counter_value   <= ctr_new;
      taken_total     <= tk_new;
      not_taken_total <= ntk_new;
    end
  end

endmodule

`default_nettype wire

FILE: src/ghbp_checker.sv
// Port-level checks for the global history branch predictor, bound to its top level.
`default_nettype none

module ghbp_checker #(
  parameter int HISTORY_BITS = ghbp_pkg::HISTORY_BITS_DEFAULT,
  parameter int COUNT_BITS   = ghbp_pkg::COUNT_BITS_DEFAULT
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          item_stall,
  input wire logic                          result_valid,
  input wire logic                          result_stall,
  input wire logic                          predicted_taken,
  input wire logic                          mispredicted,
  input wire logic [HISTORY_BITS-1:0]       entry_index,
  input wire logic [ghbp_pkg::CTR_BITS-1:0] counter_value,
  input wire logic [COUNT_BITS-1:0]         taken_total,
  input wire logic [COUNT_BITS-1:0]         not_taken_total
);

  // The table sweep after reset must hold off input words.
  a_stall_after_reset: assert property (@(posedge clk) $past(rst) |-> item_stall)
    else $error("input not stalled while the table is being initialised");

  // A mispredicted branch always leaves its counter in one of the weak states.
  a_miss_weak: assert property (@(posedge clk) disable iff (rst)
    (result_valid && mispredicted) |-> (counter_value == 2'd1 || counter_value == 2'd2))
    else $error("mispredicted word carries a saturated counter");

  // Without a misprediction the counter keeps the direction it predicted.
  a_hit_direction: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !mispredicted) |-> (counter_value[1] == predicted_taken))
    else $error("counter direction disagrees with a correct prediction");

  // A mispredicted word is an update, so it has counted at least one outcome at its entry.
  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    (result_valid && mispredicted) |-> (taken_total != '0 || not_taken_total != '0))
    else $error("mispredicted word shows no counted outcome");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(entry_index)))
    else $error("stalled result word changed");

endmodule

bind global_history_branch_predictor_core ghbp_checker #(
  .HISTORY_BITS (HISTORY_BITS),
  .COUNT_BITS   (COUNT_BITS)
) u_ghbp_checker (
  .clk             (clk),
  .rst             (rst),
  .item_stall      (item_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .predicted_taken (predicted_taken),
  .mispredicted    (mispredicted),
  .entry_index     (entry_index),
  .counter_value   (counter_value),
  .taken_total     (taken_total),
  .not_taken_total (not_taken_total)
);

`default_nettype wire
